// File: src/latency_phase_histogram_peak_assert.svh
// ---------------------------------------------------------------------------
// Latency phase histogram peak: assertion macros
// Concurrent assertion wrappers, empty when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef LATENCY_PHASE_HISTOGRAM_PEAK_ASSERT_SVH
`define LATENCY_PHASE_HISTOGRAM_PEAK_ASSERT_SVH

`ifndef SYNTHESIS
// checked property, disabled while reset is high
`define LPHP_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked property, also checked while reset is high
`define LPHP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LPHP_ASSERT(lbl, clk, rst, prop, msg)
`define LPHP_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// File: src/lphp_pkg.sv
// ---------------------------------------------------------------------------
// Latency phase histogram peak: shared package
// Widths, constants and codes of the phase histogram and its peak search.
// ---------------------------------------------------------------------------
package lphp_pkg;

   // histogram ring
   localparam int BINS      = 60;
   localparam int IDX_W     = $clog2(BINS);
   localparam int BIN_W     = 32;
   localparam int WIN_W     = BIN_W + 2;
   localparam int TOT_W     = WIN_W + $clog2(BINS);
   localparam int DEN_W     = TOT_W + 1;
   localparam int SUB_W     = DEN_W + 1;
   localparam int UPD_TAPS  = 3;

   // confidence: fraction then square root
   localparam int FRAC_BITS      = 32;
   localparam int QUO_W          = FRAC_BITS + 1;
   localparam int ROOT_W         = QUO_W + 1;
   localparam int SQRT_STEPS     = (QUO_W + 1) / 2;
   localparam int SQRT_TOP_SHIFT = 2 * (SQRT_STEPS - 1);

   // field widths
   localparam int STR_W      = 16;
   localparam int RND_W      = 8;
   localparam int BASE_W     = 10;
   localparam int LAG_W      = 10;
   localparam int CONF_W     = 16;
   localparam int CONF_MAX   = (1 << CONF_W) - 1;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 10;

   // frame counting
   localparam int ROUNDS_MAX = (1 << RND_W) - 1;
   localparam int FC_W       = $clog2(ROUNDS_MAX * BINS + 1);

   // bin index to milliseconds
   localparam int MS_PER_BIN_X1000 = 16667;
   localparam int WRAP_MS          = 1000;
   localparam int MAX_MS           = 750;
   localparam int MS_STEP_INT      = MS_PER_BIN_X1000 / WRAP_MS;
   localparam int MS_STEP_FRAC     = MS_PER_BIN_X1000 % WRAP_MS;
   localparam int MS_Q_W    = $clog2((BINS - 1) * MS_PER_BIN_X1000 / WRAP_MS + 1);
   localparam int MS_R_W    = $clog2(WRAP_MS);
   localparam int MS_BASE_W = (MS_Q_W > BASE_W) ? MS_Q_W : BASE_W;
   localparam int MSS_W     = MS_BASE_W + 2;

   // sequencer counter
   localparam int SCAN_FIRST = 4;
   localparam int SCAN_LAST  = BINS + 3;
   localparam int SC_W       = $clog2(BINS + 4);
   localparam int DIV_W      = $clog2(FRAC_BITS + 1);
   localparam int CNT_W      = (SC_W > DIV_W) ? SC_W : DIV_W;

   // command codes
   localparam logic CMD_FRAME = 1'b0;
   localparam logic CMD_START = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ROUNDS   = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_BASELINE = CSR_IDX_W'(1);

endpackage

// File: src/lphp_ram.sv
// ---------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port, one read port, read data registered.
// ---------------------------------------------------------------------------
module lphp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/latency_phase_histogram_peak.sv
// ---------------------------------------------------------------------------
// Latency phase histogram peak
// Frame-phase histogram with circular peak search, confidence and ms output.
// ---------------------------------------------------------------------------
// Usage
//   req_ channel: one beat per frame (req_command frame) or per run start
//   (req_command start). A start clears the bins and opens a run; it gives
//   no response. Frames outside a run are dropped with no response.
//   rsp_ channel: one beat per frame inside a run, carrying the latency in
//   ms, a Q0.16 confidence and a done flag on the frame that closes the run.
//   csr_ channel: index 0 rounds, index 1 baseline_ms; always ready, write
//   only between items.
// Processing
//   A counted frame goes from accept to response through 3 read-modify-writes
//   on the bin RAM, a scan over its single read port, then 33 restoring
//   divide steps and 17 square root steps on one shared subtractor. An
//   all-zero histogram skips the divide and root. Start and dropped frames
//   are handled in the idle state; the closing frame also passes through
//   the emit state.
//   req_ready is low while a frame is in work.
// Reset and stall
//   Synchronous reset clears the run, the held estimate and all bin valid
//   bits, so the bins read as zero. A response held by a stalled receiver
//   sits in the output register; the next frame is accepted meanwhile and
//   waits at its last step until that register frees.
// ---------------------------------------------------------------------------
`include "latency_phase_histogram_peak_assert.svh"

module latency_phase_histogram_peak (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_command,
   input  logic [lphp_pkg::STR_W-1:0]        req_onset_strength,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [lphp_pkg::LAG_W-1:0]        rsp_lag_ms,
   output logic [lphp_pkg::CONF_W-1:0]       rsp_confidence,
   output logic                              rsp_done_res,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [lphp_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [lphp_pkg::CSR_DATA_W-1:0]   csr_data
);

   import lphp_pkg::*;

   typedef enum logic [8:0] {
      ST_IDLE = 9'b000000001,
      ST_UPD  = 9'b000000010,
      ST_SCAN = 9'b000000100,
      ST_PREP = 9'b000001000,
      ST_DEN  = 9'b000010000,
      ST_DIV  = 9'b000100000,
      ST_SQRT = 9'b001000000,
      ST_FIN  = 9'b010000000,
      ST_EMIT = 9'b100000000
   } state_type;

   localparam logic signed [MSS_W-1:0] WRAP_S = MSS_W'(WRAP_MS);
   localparam logic signed [MSS_W-1:0] MAX_S  = MSS_W'(MAX_MS);

   // control state
   state_type             state_ff, state_in;
   logic [RND_W-1:0]      rounds_ff, rounds_in;
   logic [BASE_W-1:0]     baseline_ff, baseline_in;
   logic                  running_ff, running_in;
   logic [FC_W-1:0]       fc_ff, fc_in;
   logic [IDX_W-1:0]      phase_ff, phase_in;
   logic [LAG_W-1:0]      held_ms_ff, held_ms_in;
   logic [CONF_W-1:0]     held_conf_ff, held_conf_in;
   logic [BINS-1:0]       valid_ff, valid_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // datapath registers
   logic [LAG_W-1:0]      rsp_lag_ff, rsp_lag_in;
   logic [CONF_W-1:0]     rsp_conf_ff, rsp_conf_in;
   logic                  rsp_done_ff, rsp_done_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [IDX_W-1:0]      rp_ff, rp_in;
   logic [IDX_W-1:0]      wa_ff, wa_in;
   logic                  rd_valid_ff, rd_valid_in;
   logic [STR_W-1:0]      strength_ff, strength_in;
   logic [BIN_W-1:0]      tap_ff [3];
   logic [BIN_W-1:0]      tap_in [3];
   logic [WIN_W-1:0]      best_ff, best_in;
   logic [MS_Q_W-1:0]     best_ms_ff, best_ms_in;
   logic [TOT_W-1:0]      total_ff, total_in;
   logic [MS_Q_W-1:0]     msq_ff, msq_in;
   logic [MS_R_W-1:0]     msr_ff, msr_in;
   logic [TOT_W-1:0]      num_ff, num_in;
   logic [DEN_W-1:0]      den_ff, den_in;
   logic [DEN_W-1:0]      rem_ff, rem_in;
   logic [QUO_W-1:0]      quo_ff, quo_in;
   logic [ROOT_W-1:0]     root_ff, root_in;
   logic [ROOT_W-1:0]     sqbit_ff, sqbit_in;

   // combinational
   logic                  accept;
   logic                  out_free;
   logic                  ram_wr_en;
   logic                  ram_rd_en;
   logic [BIN_W-1:0]      ram_rd_data;
   logic [BIN_W-1:0]      bin_rd;
   logic [BIN_W:0]        sat_sum;
   logic [BIN_W-1:0]      bin_new;
   logic [WIN_W-1:0]      win_sum;
   logic [SUB_W-1:0]      sub_a;
   logic [SUB_W-1:0]      sub_b;
   logic [SUB_W:0]        sub_diff;
   logic                  sub_ge;
   logic [QUO_W-1:0]      quo_next;
   logic [MS_R_W:0]       r_sum;
   logic [FC_W-1:0]       run_limit;
   logic [IDX_W-1:0]      phase_next;
   logic [IDX_W-1:0]      rp_next;
   logic [CONF_W-1:0]     conf_sat;
   logic signed [MSS_W-1:0] ms_raw;
   logic signed [MSS_W-1:0] ms_fix;
   logic                  ms_ok;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_lag_ms     = rsp_lag_ff;
   assign rsp_confidence = rsp_conf_ff;
   assign rsp_done_res   = rsp_done_ff;

   // ring pointers and run length
   assign run_limit  = FC_W'(rounds_ff) * FC_W'(BINS);
   assign phase_next = (phase_ff == IDX_W'(BINS - 1)) ? '0 : phase_ff + IDX_W'(1);
   assign rp_next    = (rp_ff == IDX_W'(BINS - 1)) ? '0 : rp_ff + IDX_W'(1);

   // bin read, never-written bins read as zero
   assign bin_rd  = rd_valid_ff ? ram_rd_data : '0;
   assign sat_sum = {1'b0, bin_rd} + (BIN_W + 1)'(strength_ff);
   assign bin_new = sat_sum[BIN_W] ? '1 : sat_sum[BIN_W-1:0];

   // circular window sum from the three taps
   assign win_sum = WIN_W'(tap_ff[0]) + WIN_W'(tap_ff[1]) + WIN_W'(tap_ff[2]);

   // ms tracking remainder step
   assign r_sum = {1'b0, msr_ff} + (MS_R_W + 1)'(MS_STEP_FRAC);

   // shared compare-subtract unit for divide and square root
   always_comb begin
      if (state_ff == ST_DIV) begin
         sub_a = (cnt_ff == '0) ? SUB_W'(rem_ff) : {rem_ff, 1'b0};
         sub_b = SUB_W'(den_ff);
      end else begin
         sub_a = SUB_W'(rem_ff);
         sub_b = SUB_W'(root_ff + sqbit_ff);
      end
   end

   assign sub_diff = {1'b0, sub_a} - {1'b0, sub_b};
   assign sub_ge   = !sub_diff[SUB_W];
   assign quo_next = {quo_ff[QUO_W-2:0], sub_ge};

   // confidence saturation
   assign conf_sat = (root_ff > ROOT_W'(CONF_MAX)) ? CONF_W'(CONF_MAX)
                                                   : root_ff[CONF_W-1:0];

   // peak index in ms, baseline removed and wrapped
   always_comb begin
      ms_raw = $signed(MSS_W'(best_ms_ff)) - $signed(MSS_W'(baseline_ff));
      ms_fix = ms_raw;
      if (ms_fix[MSS_W-1]) begin
         ms_fix = ms_fix + WRAP_S;
      end
      if (ms_fix > WRAP_S) begin
         ms_fix = ms_fix - WRAP_S;
      end
      ms_ok = !ms_fix[MSS_W-1] && !(ms_fix > MAX_S);
   end

   // sequencer and next-state logic
   always_comb begin
      state_in     = state_ff;
      rounds_in    = rounds_ff;
      baseline_in  = baseline_ff;
      running_in   = running_ff;
      fc_in        = fc_ff;
      phase_in     = phase_ff;
      held_ms_in   = held_ms_ff;
      held_conf_in = held_conf_ff;
      valid_in     = valid_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_lag_in   = rsp_lag_ff;
      rsp_conf_in  = rsp_conf_ff;
      rsp_done_in  = rsp_done_ff;
      done_in      = done_ff;
      cnt_in       = cnt_ff;
      rp_in        = rp_ff;
      wa_in        = wa_ff;
      rd_valid_in  = rd_valid_ff;
      strength_in  = strength_ff;
      tap_in       = tap_ff;
      best_in      = best_ff;
      best_ms_in   = best_ms_ff;
      total_in     = total_ff;
      msq_in       = msq_ff;
      msr_in       = msr_ff;
      num_in       = num_ff;
      den_in       = den_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      root_in      = root_ff;
      sqbit_in     = sqbit_ff;
      ram_wr_en    = 1'b0;
      ram_rd_en    = 1'b0;

      // register writes
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ROUNDS:   rounds_in   = csr_data[RND_W-1:0];
            CSR_BASELINE: baseline_in = csr_data[BASE_W-1:0];
            default: ;
         endcase
      end

      // response beat taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_command == CMD_START) begin
                  valid_in   = '0;
                  running_in = 1'b1;
                  fc_in      = '0;
                  phase_in   = '0;
               end else if (running_ff) begin
                  if (fc_ff >= run_limit) begin
                     running_in = 1'b0;
                     done_in    = 1'b1;
                     state_in   = ST_EMIT;
                  end else begin
                     fc_in       = fc_ff + FC_W'(1);
                     phase_in    = phase_next;
                     rp_in       = phase_ff;
                     strength_in = req_onset_strength;
                     cnt_in      = '0;
                     done_in     = 1'b0;
                     state_in    = ST_UPD;
                  end
               end
            end
         end

         // read-modify-write of the three bins around the new phase
         ST_UPD: begin
            if (cnt_ff != CNT_W'(UPD_TAPS)) begin
               ram_rd_en   = 1'b1;
               rd_valid_in = valid_ff[rp_ff];
               wa_in       = rp_ff;
               rp_in       = rp_next;
            end
            if (cnt_ff != '0) begin
               ram_wr_en       = 1'b1;
               valid_in[wa_ff] = 1'b1;
            end
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(UPD_TAPS)) begin
               state_in   = ST_SCAN;
               cnt_in     = '0;
               rp_in      = IDX_W'(BINS - 1);
               best_in    = '0;
               best_ms_in = '0;
               total_in   = '0;
               msq_in     = '0;
               msr_in     = '0;
            end
         end

         // stream the ring from the last bin round to bin 0 again
         ST_SCAN: begin
            if (cnt_ff <= CNT_W'(BINS + 1)) begin
               ram_rd_en   = 1'b1;
               rd_valid_in = valid_ff[rp_ff];
               rp_in       = rp_next;
            end
            tap_in[0] = tap_ff[1];
            tap_in[1] = tap_ff[2];
            tap_in[2] = bin_rd;
            if (cnt_ff >= CNT_W'(SCAN_FIRST)) begin
               if (win_sum > best_ff) begin
                  best_in    = win_sum;
                  best_ms_in = msq_ff;
               end
               total_in = total_ff + TOT_W'(win_sum);
               if (r_sum >= (MS_R_W + 1)'(WRAP_MS)) begin
                  msr_in = MS_R_W'(r_sum - (MS_R_W + 1)'(WRAP_MS));
                  msq_in = msq_ff + MS_Q_W'(MS_STEP_INT + 1);
               end else begin
                  msr_in = r_sum[MS_R_W-1:0];
                  msq_in = msq_ff + MS_Q_W'(MS_STEP_INT);
               end
            end
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(SCAN_LAST)) begin
               state_in = ST_PREP;
            end
         end

         ST_PREP: begin
            num_in   = TOT_W'(best_ff) * TOT_W'(BINS);
            state_in = ST_DEN;
         end

         // denominator; all-zero histogram gives zero confidence
         ST_DEN: begin
            den_in = DEN_W'(num_ff) + DEN_W'(total_ff);
            rem_in = DEN_W'(num_ff);
            quo_in = '0;
            cnt_in = '0;
            if (total_ff == '0) begin
               root_in  = '0;
               state_in = ST_FIN;
            end else begin
               state_in = ST_DIV;
            end
         end

         // restoring divide, one quotient bit a cycle
         ST_DIV: begin
            rem_in = sub_ge ? sub_diff[DEN_W-1:0] : sub_a[DEN_W-1:0];
            quo_in = quo_next;
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(FRAC_BITS)) begin
               rem_in   = DEN_W'(quo_next);
               root_in  = '0;
               sqbit_in = ROOT_W'(1) << SQRT_TOP_SHIFT;
               cnt_in   = '0;
               state_in = ST_SQRT;
            end
         end

         // digit-by-digit square root, two radicand bits a cycle
         ST_SQRT: begin
            if (sub_ge) begin
               rem_in  = sub_diff[DEN_W-1:0];
               root_in = (root_ff >> 1) + sqbit_ff;
            end else begin
               root_in = root_ff >> 1;
            end
            sqbit_in = sqbit_ff >> 2;
            cnt_in   = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(SQRT_STEPS - 1)) begin
               state_in = ST_FIN;
            end
         end

         ST_FIN: begin
            held_ms_in   = ms_ok ? ms_fix[LAG_W-1:0] : '0;
            held_conf_in = ms_ok ? conf_sat : '0;
            state_in     = ST_EMIT;
         end

         // load the output register once it is free
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_lag_in   = held_ms_ff;
               rsp_conf_in  = held_conf_ff;
               rsp_done_in  = done_ff;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rounds_ff    <= RND_W'(10);
         baseline_ff  <= '0;
         running_ff   <= 1'b0;
         fc_ff        <= '0;
         phase_ff     <= '0;
         held_ms_ff   <= '0;
         held_conf_ff <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rounds_ff    <= rounds_in;
         baseline_ff  <= baseline_in;
         running_ff   <= running_in;
         fc_ff        <= fc_in;
         phase_ff     <= phase_in;
         held_ms_ff   <= held_ms_in;
         held_conf_ff <= held_conf_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      rsp_lag_ff  <= rsp_lag_in;
      rsp_conf_ff <= rsp_conf_in;
      rsp_done_ff <= rsp_done_in;
      done_ff     <= done_in;
      cnt_ff      <= cnt_in;
      rp_ff       <= rp_in;
      wa_ff       <= wa_in;
      rd_valid_ff <= rd_valid_in;
      strength_ff <= strength_in;
      tap_ff      <= tap_in;
      best_ff     <= best_in;
      best_ms_ff  <= best_ms_in;
      total_ff    <= total_in;
      msq_ff      <= msq_in;
      msr_ff      <= msr_in;
      num_ff      <= num_in;
      den_ff      <= den_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      root_ff     <= root_in;
      sqbit_ff    <= sqbit_in;
   end

   // bin store
   lphp_ram #(
      .WIDTH (BIN_W),
      .DEPTH (BINS)
   ) u_bins (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (wa_ff),
      .wr_data (bin_new),
      .rd_en   (ram_rd_en),
      .rd_addr (rp_ff),
      .rd_data (ram_rd_data)
   );

   // checks
   `LPHP_ASSERT(a_held_ms_range, clock, reset, held_ms_ff <= LAG_W'(MAX_MS),
                "held latency above limit")
   `LPHP_ASSERT(a_phase_range, clock, reset, phase_ff <= IDX_W'(BINS - 1),
                "phase pointer off the ring")
   `LPHP_ASSERT(a_div_rem, clock, reset,
                (state_ff == ST_DIV) && (cnt_ff != '0) |-> rem_ff < den_ff,
                "divide remainder not below divisor")
   `LPHP_ASSERT(a_scan_in_run, clock, reset,
                (state_ff == ST_UPD) || (state_ff == ST_SCAN) |-> running_ff,
                "bin work outside a run")
   `LPHP_ASSERT_ALWAYS(a_rsp_source, clock,
                       $rose(rsp_valid_ff) |-> $past(state_ff == ST_EMIT),
                       "response beat raised outside emit")

endmodule

// File: tb/tb.sv
// ---------------------------------------------------------------------------
// Latency phase histogram peak: testbench
// Sends start and frame beats with random gaps against a randomly stalling
// receiver, predicts each estimate from a behavioural copy of the histogram
// and its peak search, and checks every response beat field by field.
// ---------------------------------------------------------------------------
module tb;
   import lphp_pkg::*;

   localparam int CLK_PERIOD       = 8;
   localparam int RESET_CYCLES     = 4;
   localparam int SETTLE_CYCLES    = 160;
   localparam int LONG_HOLD_CYCLES = 3000;
   localparam int TIMEOUT_CYCLES   = 600000;
   localparam int RANDOM_ITEMS     = 430;
   localparam int MAX_REPORTS      = 10;
   localparam int ROUNDS_AT_RESET  = 10;

   typedef struct packed {
      logic             command;
      logic [STR_W-1:0] strength;
   } frame_beat_type;

   typedef struct packed {
      logic [LAG_W-1:0]  lag_ms;
      logic [CONF_W-1:0] confidence;
      logic              done;
   } estimate_type;

   logic                  clock;
   logic                  reset              = 1'b1;
   logic                  req_valid          = 1'b0;
   logic                  req_ready;
   logic                  req_command        = CMD_FRAME;
   logic [STR_W-1:0]      req_onset_strength = '0;
   logic                  rsp_valid;
   logic                  rsp_ready          = 1'b0;
   logic [LAG_W-1:0]      rsp_lag_ms;
   logic [CONF_W-1:0]     rsp_confidence;
   logic                  rsp_done_res;
   logic                  csr_valid          = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index          = CSR_ROUNDS;
   logic [CSR_DATA_W-1:0] csr_data           = '0;

   // predicted block state and register copies
   logic [BIN_W-1:0]  model_bins [BINS];
   logic              model_running;
   int                model_frames;
   logic [LAG_W-1:0]  model_lag;
   logic [CONF_W-1:0] model_conf;
   logic [RND_W-1:0]  model_rounds;
   logic [BASE_W-1:0] model_baseline;

   frame_beat_type pending_beats [$];
   estimate_type   due_estimates [$];

   int   send_idle_pct  = 32;
   int   recv_idle_pct  = 62;
   logic stall_armed    = 1'b0;
   logic long_hold_done = 1'b0;
   int   hold_count     = 0;
   int   fault_count    = 0;

   latency_phase_histogram_peak DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_command        (req_command),
      .req_onset_strength (req_onset_strength),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_lag_ms         (rsp_lag_ms),
      .rsp_confidence     (rsp_confidence),
      .rsp_done_res       (rsp_done_res),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   // apply one accepted request beat to the predicted histogram
   function automatic void advance_histogram(input frame_beat_type beat);
      logic [BIN_W:0]    bin_sum;
      logic [63:0]       window;
      logic [63:0]       best_sum;
      logic [63:0]       total;
      logic [63:0]       weighted;
      logic [95:0]       ratio;
      logic [63:0]       root;
      logic [63:0]       trial;
      logic [CONF_W-1:0] conf;
      int                best_idx;
      int                slot;
      int                lag;
      if (beat.command == CMD_START) begin
         foreach (model_bins[i]) model_bins[i] = '0;
         model_running = 1'b1;
         model_frames  = 0;
         return;
      end
      if (!model_running) return;
      // run complete: held estimate comes back flagged as done
      if (model_frames >= int'(model_rounds) * BINS) begin
         model_running = 1'b0;
         due_estimates.push_back({model_lag, model_conf, 1'b1});
         return;
      end
      model_frames++;
      // three taps around the new phase, each saturating
      for (int t = -1; t <= 1; t++) begin
         slot = (model_frames + BINS + t) % BINS;
         bin_sum = {1'b0, model_bins[slot]} + beat.strength;
         model_bins[slot] = bin_sum[BIN_W] ? {BIN_W{1'b1}} : bin_sum[BIN_W-1:0];
      end
      // circular 3-bin window scan, first strict maximum wins
      best_sum = '0;
      best_idx = 0;
      total    = '0;
      for (int i = 0; i < BINS; i++) begin
         window = 64'(model_bins[(i + BINS - 1) % BINS]) + 64'(model_bins[i])
                + 64'(model_bins[(i + 1) % BINS]);
         if (window > best_sum) begin
            best_sum = window;
            best_idx = i;
         end
         total += window;
      end
      // confidence: square root of the Q0.32 ratio best / (best + mean)
      weighted = best_sum * 64'(BINS);
      if (weighted + total == 0) begin
         conf = '0;
      end else begin
         ratio = (96'(weighted) << FRAC_BITS) / 96'(weighted + total);
         root  = '0;
         for (int b = 16; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= ratio[63:0]) root = trial;
         end
         conf = (root > 64'(CONF_MAX)) ? CONF_W'(CONF_MAX) : root[CONF_W-1:0];
      end
      // bin index to ms, baseline removed, wrapped and range limited
      lag = (best_idx * MS_PER_BIN_X1000) / WRAP_MS - int'(model_baseline);
      if (lag < 0) lag += WRAP_MS;
      if (lag > WRAP_MS) lag -= WRAP_MS;
      if (lag < 0 || lag > MAX_MS) begin
         lag  = 0;
         conf = '0;
      end
      model_lag  = LAG_W'(lag);
      model_conf = conf;
      due_estimates.push_back({model_lag, model_conf, 1'b0});
   endfunction

   function automatic void log_fault(input string msg);
      fault_count++;
      if (fault_count <= MAX_REPORTS) $display("%0t: %s", $time, msg);
   endfunction

   function automatic void queue_beat(input logic command, input logic [STR_W-1:0] strength);
      pending_beats.push_back({command, strength});
   endfunction

   // onset strength for frame k of a run, sometimes shaped around a peak
   function automatic logic [STR_W-1:0] onset_for(input int k, input int peak_at);
      case ($urandom_range(0, 3))
         0: return STR_W'($urandom);
         1: return STR_W'($urandom_range(0, 255));
         2: return ($urandom_range(0, 1) == 1) ? {STR_W{1'b1}} : {STR_W{1'b0}};
         default: begin
            if ((k - peak_at + BINS) % BINS < 3)
               return STR_W'($urandom_range(40000, 65535));
            return STR_W'($urandom_range(0, 2000));
         end
      endcase
   endfunction

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_ROUNDS) model_rounds = value[RND_W-1:0];
      else model_baseline = value[BASE_W-1:0];
   endtask

   // wait for every beat to go out and every estimate to return
   task automatic drain();
      while (pending_beats.size() != 0 || req_valid || due_estimates.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // request driver: a beat stays on the port until accepted
   always @(posedge clock) begin : request_drive
      frame_beat_type next_beat;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            advance_histogram({req_command, req_onset_strength});
         if (!req_valid || req_ready) begin
            if (pending_beats.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               next_beat = pending_beats.pop_front();
               req_valid          <= 1'b1;
               req_command        <= next_beat.command;
               req_onset_strength <= next_beat.strength;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver ready, with one long hold-off once armed
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (stall_armed && !long_hold_done) begin
         rsp_ready <= 1'b0;
         if (hold_count == LONG_HOLD_CYCLES) long_hold_done <= 1'b1;
         else hold_count <= hold_count + 1;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // response check against the oldest predicted estimate
   always @(posedge clock) begin : result_check
      estimate_type got;
      estimate_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = {rsp_lag_ms, rsp_confidence, rsp_done_res};
         if (due_estimates.size() == 0) begin
            log_fault($sformatf("unexpected estimate: lag %0d conf %0d done %0b",
                                got.lag_ms, got.confidence, got.done));
         end else begin
            want = due_estimates.pop_front();
            if (got.lag_ms !== want.lag_ms || got.confidence !== want.confidence ||
                got.done !== want.done)
               log_fault($sformatf({"estimate mismatch: expected lag %0d conf %0d done %0b,",
                                    " got lag %0d conf %0d done %0b"},
                                   want.lag_ms, want.confidence, want.done,
                                   got.lag_ms, got.confidence, got.done));
         end
      end
   end

   initial begin : stimulus
      int                    fed;
      int                    phase_no;
      int                    run_frames;
      int                    peak_at;
      logic [CSR_DATA_W-1:0] rounds_word;
      foreach (model_bins[i]) model_bins[i] = '0;
      model_running  = 1'b0;
      model_frames   = 0;
      model_lag      = '0;
      model_conf     = '0;
      model_rounds   = RND_W'(ROUNDS_AT_RESET);
      model_baseline = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // frame outside a run is dropped
      queue_beat(CMD_FRAME, 16'hFFFF);
      // empty histogram first, then strength extremes and bit patterns
      queue_beat(CMD_START, 16'h0000);
      queue_beat(CMD_FRAME, 16'h0000);
      queue_beat(CMD_FRAME, 16'hFFFF);
      queue_beat(CMD_FRAME, 16'h0001);
      queue_beat(CMD_FRAME, 16'hAAAA);
      queue_beat(CMD_FRAME, 16'h5555);
      queue_beat(CMD_FRAME, 16'h8000);
      // restart in the middle of a run
      queue_beat(CMD_START, 16'hFFFF);
      queue_beat(CMD_FRAME, 16'h7FFF);
      queue_beat(CMD_FRAME, 16'hFFFF);
      drain();

      // baseline past the wrap: early peaks stay negative and are zeroed
      write_reg(CSR_BASELINE, {CSR_DATA_W{1'b1}});
      queue_beat(CMD_START, 16'h0000);
      queue_beat(CMD_FRAME, 16'h0100);
      queue_beat(CMD_FRAME, 16'hFFFF);
      queue_beat(CMD_FRAME, 16'hFFFF);
      queue_beat(CMD_FRAME, 16'hFFFF);
      drain();

      // zero rounds: the first frame closes the run
      write_reg(CSR_ROUNDS, '0);
      write_reg(CSR_BASELINE, CSR_DATA_W'(WRAP_MS));
      queue_beat(CMD_START, 16'h0000);
      queue_beat(CMD_FRAME, 16'h1234);
      queue_beat(CMD_FRAME, 16'h4321);
      drain();

      // random runs, mostly well formed, idling pattern changing by thirds
      fed      = 0;
      phase_no = 0;
      while (fed < RANDOM_ITEMS) begin
         if (fed < RANDOM_ITEMS / 3) begin
            send_idle_pct = 32;
            recv_idle_pct = 62;
         end else if (fed < 2 * RANDOM_ITEMS / 3) begin
            send_idle_pct = 62;
            recv_idle_pct = 32;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end

         // mostly single-round runs so that they close
         case ($urandom_range(0, 9))
            0, 1: rounds_word = CSR_DATA_W'($urandom_range(2, 3));
            2: rounds_word = {2'b11, RND_W'(1)};   // bits above rounds are dropped
            default: rounds_word = CSR_DATA_W'(1);
         endcase
         if (phase_no == 1) rounds_word = CSR_DATA_W'(ROUNDS_MAX);
         write_reg(CSR_ROUNDS, rounds_word);
         case ($urandom_range(0, 5))
            0: write_reg(CSR_BASELINE, '0);
            1: write_reg(CSR_BASELINE, CSR_DATA_W'(WRAP_MS));
            2: write_reg(CSR_BASELINE, CSR_DATA_W'($urandom_range(0, 1023)));
            default: write_reg(CSR_BASELINE, CSR_DATA_W'($urandom_range(0, 300)));
         endcase

         run_frames = (rounds_word[RND_W-1:0] == RND_W'(1)) ? $urandom_range(58, 64)
                                                             : $urandom_range(25, 60);
         peak_at = $urandom_range(0, BINS - 1);
         // long receiver hold-off while frames keep coming
         if (phase_no == 2) stall_armed <= 1'b1;

         // stray frame ahead of the start now and then
         if ($urandom_range(0, 3) == 0) begin
            queue_beat(CMD_FRAME, STR_W'($urandom));
            fed++;
         end
         queue_beat(CMD_START, STR_W'($urandom));
         fed++;
         for (int k = 1; k <= run_frames; k++) begin
            // occasional restart breaks the run
            if ($urandom_range(0, 49) == 0) begin
               queue_beat(CMD_START, STR_W'($urandom));
               fed++;
            end
            queue_beat(CMD_FRAME, onset_for(k, peak_at));
            fed++;
         end
         drain();
         phase_no++;
      end

      if (fault_count == 0 && due_estimates.size() == 0)
         $display("latency_phase_histogram_peak verification clean");
      else
         $display("latency_phase_histogram_peak verification failed");
      $finish;
   end

   // hard stop if the run hangs
   initial begin : watchdog
      #(CLK_PERIOD * TIMEOUT_CYCLES);
      $display("latency_phase_histogram_peak verification failed");
      $finish;
   end

endmodule
